@@ hw/rtl/sha1mh_pkg.sv @@
// sha1mh_pkg: shared types, constants and round functions for the sha-1 message hasher
// no dependencies

package sha1mh_pkg;

	typedef logic [31:0] word_t;

	localparam int unsigned CHAIN_WORDS = 5;
	localparam int unsigned ROUNDS      = 80;

	localparam word_t H_INIT [CHAIN_WORDS] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam word_t K_00_19 = 32'h5A827999;
	localparam word_t K_20_39 = 32'h6ED9EBA1;
	localparam word_t K_40_59 = 32'h8F1BBCDC;
	localparam word_t K_60_79 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [5:0] BLOCK_LAST = 6'd63;
	localparam logic [2:0] LAST_INDEX = 3'd4;

	function automatic word_t round_f(input logic [6:0] r, input word_t b, input word_t c,
		input word_t d);
		word_t res;
		if (r < 7'd20) begin
			res = (b & c) | (~b & d);
		end else if (r < 7'd40) begin
			res = b ^ c ^ d;
		end else if (r < 7'd60) begin
			res = (b & c) | (b & d) | (c & d);
		end else begin
			res = b ^ c ^ d;
		end
		return res;
	endfunction

	function automatic word_t round_k(input logic [6:0] r);
		word_t res;
		if (r < 7'd20) begin
			res = K_00_19;
		end else if (r < 7'd40) begin
			res = K_20_39;
		end else if (r < 7'd60) begin
			res = K_40_59;
		end else begin
			res = K_60_79;
		end
		return res;
	endfunction

endpackage

@@ hw/rtl/sha1_message_hasher_unit.sv @@
// sha1_message_hasher_unit: byte-wide sha-1 hasher, top level
// depends on sha1mh_pkg

// Message bytes enter one per input transaction and are packed big-endian into a
// 16-word block memory with a registered read. The transaction that fills a
// 64-byte block is followed by the compression: a load step that fetches word 0
// and loads the working variables, 80 rounds at one per cycle (rounds 0-15 read
// the block memory one word ahead, later rounds take the schedule from a 16-word
// window), and a chaining add. A transaction with message_end then writes the
// padding and the 64-bit bit count at one byte per cycle, with a compression for
// each block it fills, and offers the five digest words H0..H4 as five output
// transactions, the fifth marked by last_word. Input is not taken until the last
// digest word has been accepted; the hasher is then ready for a new message.

module sha1_message_hasher_unit import sha1mh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        message_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_CLOAD,
		ST_ROUND,
		ST_CADD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_80,
		PH_ZERO,
		PH_LEN
	} pad_t;

	state_t      st_q;
	state_t      ret_q;
	pad_t        pad_q;
	logic [5:0]  pos_q;
	logic [63:0] bits_q;
	logic [63:0] len_q;
	logic [6:0]  round_q;
	logic [2:0]  idx_q;
	word_t       chain_q [CHAIN_WORDS];

	word_t       blk_mem [16];
	word_t       rdata_q;
	word_t       acc_q;
	word_t       win_q [16];
	word_t       a_q, b_q, c_q, d_q, e_q;

	logic        in_acc;
	logic        push_en;
	logic [7:0]  push_byte;
	word_t       acc_next;
	logic        mem_we;
	logic [3:0]  raddr;
	word_t       sched;
	word_t       w_cur;
	word_t       tmp;

	assign in_ready    = (st_q == ST_IDLE);
	assign in_acc      = in_valid && in_ready;
	assign out_valid   = (st_q == ST_OUT);
	assign digest_word = chain_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == LAST_INDEX);

	// byte packing path, shared by message bytes and padding
	always_comb begin
		push_en   = 1'b0;
		push_byte = '0;
		if (in_acc && byte_valid) begin
			push_en   = 1'b1;
			push_byte = data_byte;
		end else if (st_q == ST_PAD) begin
			push_en = 1'b1;
			case (pad_q)
				PH_80:   push_byte = PAD_BYTE;
				PH_LEN:  push_byte = len_q[63:56];
				default: push_byte = '0;
			endcase
		end
	end

	assign acc_next = {acc_q[23:0], push_byte};
	assign mem_we   = push_en && (pos_q[1:0] == 2'b11);
	assign raddr    = (st_q == ST_ROUND) ? round_q[3:0] + 4'd1 : 4'd0;

	// round datapath
	assign sched = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign w_cur = (round_q < 7'd16) ? rdata_q : {sched[30:0], sched[31]};
	assign tmp   = {a_q[26:0], a_q[31:27]} + round_f(round_q, b_q, c_q, d_q) + e_q
		+ round_k(round_q) + w_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			ret_q   <= ST_IDLE;
			pad_q   <= PH_80;
			pos_q   <= '0;
			bits_q  <= '0;
			len_q   <= '0;
			round_q <= '0;
			idx_q   <= '0;
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				chain_q[i] <= H_INIT[i];
			end
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (byte_valid) begin
							pos_q  <= pos_q + 6'd1;
							bits_q <= bits_q + 64'd8;
						end
						if (message_end) begin
							len_q <= bits_q + (byte_valid ? 64'd8 : 64'd0);
							pad_q <= PH_80;
						end
						if (byte_valid && pos_q == BLOCK_LAST) begin
							st_q  <= ST_CLOAD;
							ret_q <= message_end ? ST_PAD : ST_IDLE;
						end else if (message_end) begin
							st_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pos_q <= pos_q + 6'd1;
					case (pad_q)
						PH_80:   pad_q <= (pos_q == LEN_POS - 6'd1) ? PH_LEN : PH_ZERO;
						PH_ZERO: if (pos_q == LEN_POS - 6'd1) pad_q <= PH_LEN;
						default: len_q <= {len_q[55:0], 8'h00};
					endcase
					if (pos_q == BLOCK_LAST) begin
						st_q  <= ST_CLOAD;
						ret_q <= (pad_q == PH_LEN) ? ST_OUT : ST_PAD;
					end
				end
				ST_CLOAD: begin
					round_q <= '0;
					st_q    <= ST_ROUND;
				end
				ST_ROUND: begin
					round_q <= round_q + 7'd1;
					if (round_q == 7'(ROUNDS - 1)) begin
						st_q <= ST_CADD;
					end
				end
				ST_CADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
					idx_q      <= '0;
					st_q       <= ret_q;
				end
				ST_OUT: begin
					if (out_ready) begin
						if (idx_q == LAST_INDEX) begin
							for (int i = 0; i < CHAIN_WORDS; i++) begin
								chain_q[i] <= H_INIT[i];
							end
							pos_q  <= '0;
							bits_q <= '0;
							idx_q  <= '0;
							st_q   <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// block memory, packing word and round registers
	always_ff @(posedge clk) begin
		if (mem_we) begin
			blk_mem[pos_q[5:2]] <= acc_next;
		end
		rdata_q <= blk_mem[raddr];
		if (push_en) begin
			acc_q <= acc_next;
		end
		if (st_q == ST_CLOAD) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end
		if (st_q == ST_ROUND) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= w_cur;
		end
	end

endmodule

@@ bench/sha1_digest_checker.sv @@
// sha1_digest_checker: watches both channels of the sha-1 message hasher, predicts
// the digest words of each closed message and compares every output transaction
// depends on sha1mh_pkg

module sha1_digest_checker import sha1mh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        message_end,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int unsigned pending_words,
	output int unsigned failures
);

	typedef struct packed {
		word_t      word_val;
		logic [2:0] idx;
		logic       is_last;
	} digest_beat_t;

	word_t        chain [CHAIN_WORDS];
	word_t        msg_block [16];
	logic [5:0]   fill_pos;
	logic [63:0]  bit_count;
	digest_beat_t expected_digest [$];
	digest_beat_t beat;
	int unsigned  mismatches = 0;

	assign failures = mismatches;

	function automatic word_t rotl(input word_t x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function void compress_block();
		word_t w [16];
		word_t a, b, c, d, e, f, k, t;
		int    r;
		w = msg_block;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (r = 0; r < ROUNDS; r++) begin
			if (r >= 16) begin
				w[r % 16] = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^
					w[r % 16], 1);
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K_00_19;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_20_39;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_40_59;
			end else begin
				f = b ^ c ^ d;
				k = K_60_79;
			end
			t = rotl(a, 5) + f + e + k + w[r % 16];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
		chain[4] += e;
	endfunction

	function void absorb_byte(input logic [7:0] value);
		int unsigned shift;
		shift = (3 - int'(fill_pos[1:0])) * 8;
		msg_block[fill_pos[5:2]][shift +: 8] = value;
		fill_pos = fill_pos + 6'd1;
		if (fill_pos == 6'd0) begin
			compress_block();
		end
	endfunction

	function void restart_message();
		chain = H_INIT;
		fill_pos = 6'd0;
		bit_count = 64'd0;
	endfunction

	function void close_message();
		logic [63:0]  len;
		digest_beat_t nb;
		int           i;
		len = bit_count;
		absorb_byte(PAD_BYTE);
		while (fill_pos != LEN_POS) begin
			absorb_byte(8'h00);
		end
		for (i = 0; i < 8; i++) begin
			absorb_byte(len[63 - 8 * i -: 8]);
		end
		for (i = 0; i < CHAIN_WORDS; i++) begin
			nb.word_val = chain[i];
			nb.idx = 3'(i);
			nb.is_last = (3'(i) == LAST_INDEX);
			expected_digest.push_back(nb);
		end
		restart_message();
	endfunction

	task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("digest check: %s got %h want %h", what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_message();
			expected_digest.delete();
			pending_words <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_digest.size() == 0) begin
					report_mismatch("unexpected transaction", digest_word, 32'd0);
				end else begin
					beat = expected_digest.pop_front();
					if (digest_word !== beat.word_val) begin
						report_mismatch("digest_word", digest_word, beat.word_val);
					end
					if (word_index !== beat.idx) begin
						report_mismatch("word_index", {29'd0, word_index}, {29'd0, beat.idx});
					end
					if (last_word !== beat.is_last) begin
						report_mismatch("last_word", {31'd0, last_word}, {31'd0, beat.is_last});
					end
				end
			end
			if (in_valid && in_ready) begin
				if (byte_valid) begin
					absorb_byte(data_byte);
					bit_count += 64'd8;
				end
				if (message_end) begin
					close_message();
				end
			end
			pending_words <= expected_digest.size();
		end
	end

endmodule

@@ bench/sha1_message_hasher_unit_tb.sv @@
// sha1_message_hasher_unit_tb: drives messages into the sha-1 hasher with random
// gaps and back-pressure; checking is done by sha1_digest_checker
// depends on sha1_digest_checker and sha1_message_hasher_unit

module sha1_message_hasher_unit_tb;

	localparam int unsigned STALL_LIMIT  = 4000;
	localparam int unsigned RANDOM_ITEMS = 130;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        byte_valid;
	logic        message_end;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	int unsigned pending_words;
	int unsigned failures;
	int unsigned quiet_cycles;
	int unsigned msg_items;
	logic        sender_steady;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	sha1_message_hasher_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.byte_valid  (byte_valid),
		.message_end (message_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	sha1_digest_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.byte_valid    (byte_valid),
		.message_end   (message_end),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.digest_word   (digest_word),
		.word_index    (word_index),
		.last_word     (last_word),
		.pending_words (pending_words),
		.failures      (failures)
	);

	task automatic send_item(input logic [7:0] value, input logic has_byte, input logic ends);
		@(negedge clk);
		while (!sender_steady && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= value;
		byte_valid <= has_byte;
		message_end <= ends;
		do begin
			@(posedge clk);
		end while (!in_ready);
		msg_items++;
	endtask

	task automatic drain_digests();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_words != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic send_message(input int unsigned len);
		logic        end_on_byte;
		int unsigned i;
		end_on_byte = (len != 0) && ($urandom_range(1) == 1);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(19) == 0) begin
				send_item(8'($urandom), 1'b0, 1'b0);
			end
			send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
		end
		if (!end_on_byte) begin
			send_item(8'($urandom), 1'b0, 1'b1);
		end
	endtask

	// receiver: random stalls, a clean stretch, and one long hold-off
	initial begin
		int unsigned n;
		logic        held;
		out_ready = 1'b0;
		n = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n++;
			if (!held && n >= 450 && out_valid && in_valid) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
			end else begin
				out_ready <= (n >= 100 && n < 350) || ($urandom_range(99) >= 23);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("sha1_message_hasher_unit: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned len;
		int unsigned msg_no;
		logic        paused;
		in_valid = 1'b0;
		data_byte = 8'h00;
		byte_valid = 1'b0;
		message_end = 1'b0;
		arst_n = 1'b0;
		sender_steady = 1'b0;
		msg_items = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// idle transaction, then the empty message
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'ha5, 1'b0, 1'b1);
		// "abc" closed on its last byte
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		// extremes with an idle transaction inside, closed by a bare end
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'h55, 1'b1, 1'b0);
		send_item(8'haa, 1'b1, 1'b0);
		send_item(8'h0f, 1'b1, 1'b0);
		send_item(8'hf0, 1'b1, 1'b0);
		send_item(8'h3c, 1'b0, 1'b1);

		msg_no = 0;
		paused = 1'b0;
		while (msg_items < RANDOM_ITEMS) begin
			sender_steady = (msg_items >= 20 && msg_items < 50);
			if (!paused && msg_items >= 60) begin
				drain_digests();
				paused = 1'b1;
			end
			if ($urandom_range(9) == 0) begin
				send_item(8'($urandom), 1'b0, 1'b0);
			end
			if (msg_no == 2) begin
				len = 55 + $urandom_range(1);
			end else if ($urandom_range(11) == 0) begin
				len = $urandom_range(65, 56);
			end else begin
				len = $urandom_range(12);
			end
			send_message(len);
			msg_no++;
		end
		sender_steady = 1'b0;

		drain_digests();
		repeat (50) @(negedge clk);
		if (failures == 0) begin
			$display("sha1_message_hasher_unit: match");
		end else begin
			$display("sha1_message_hasher_unit: mismatch");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/sha1mh_pkg.sv
hw/rtl/sha1_message_hasher_unit.sv
bench/sha1_digest_checker.sv
bench/sha1_message_hasher_unit_tb.sv
